FILE: src/saturating_signed_alu_defines.svh
// ----------------------------------------------------------------------------
// Saturating signed ALU assertion macros
// Shared wrappers for the concurrent checks on the ALU ports.
// ----------------------------------------------------------------------------
`ifndef SATURATING_SIGNED_ALU_DEFINES_SVH
`define SATURATING_SIGNED_ALU_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SSALU_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SSALU_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ssalu_pkg.sv
// ----------------------------------------------------------------------------
// Saturating signed ALU package
// Operation codes and default width shared by the ALU and its checker.
// ----------------------------------------------------------------------------
package ssalu_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int OP_WIDTH           = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

FILE: src/saturating_signed_alu.sv
// ----------------------------------------------------------------------------
// Saturating signed ALU
// Pipelined add, subtract, multiply and divide with signed saturation.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) carries an operation code and
//   two signed operands. The response channel (rsp_valid / rsp_stall) returns
//   the saturated result and a divide-by-zero flag, one per transaction, in
//   order. A transaction moves on a rising edge with valid high, stall low.
//   A transaction passes the input register, the prepare register, the
//   DATA_WIDTH divide and multiply stages and the response register.
//   Throughput: one transaction per cycle while no held response is stalled.
//   Each stage retires one quotient bit and one partial product in parallel.
//   Reset (synchronous, active high) clears all valid bits; in-flight
//   transactions are dropped. When the receiver stalls a held response, the
//   whole pipeline freezes and req_stall rises in the same cycle, so nothing
//   is lost or repeated. Divide by zero returns zero with the flag set.
// ----------------------------------------------------------------------------
module saturating_signed_alu
   import ssalu_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_WIDTH-1:0]          req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_result,
   output logic                         rsp_divide_by_zero
);

   localparam int W      = DATA_WIDTH;
   localparam int STAGES = DATA_WIDTH;

   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      op_type         op;
      logic           neg;
      logic           dz;
      logic [W-1:0]   asr;
      logic [W-1:0]   dvs;
      logic [W:0]     rem;
      logic [W-1:0]   quo;
      logic [2*W-1:0] mcand;
      logic [W-1:0]   mplier;
      logic [2*W-1:0] prod;
   } stage_type;

   logic                     adv;
   logic                     in_vld_ff;
   op_type                   in_op_ff;
   logic [W-1:0]             in_a_ff;
   logic [W-1:0]             in_b_ff;
   stage_type                prep_in;
   stage_type                pipe_ff [0:STAGES];
   stage_type                pipe_in [1:STAGES];
   logic                     vld_ff  [0:STAGES];
   logic                     rsp_valid_ff;
   logic [W-1:0]             result_ff;
   logic [W-1:0]             result_in;
   logic                     dz_ff;

   // Freeze everything while a finished transaction waits to be taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Capture incoming operands
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
      if (adv && req_valid) begin
         in_op_ff <= op_type'(req_operation);
         in_a_ff  <= req_operand_a;
         in_b_ff  <= req_operand_b;
      end
   end

   // Prepare: add/subtract with saturation, magnitudes, signs
   always_comb begin
      logic         sa;
      logic         sb;
      logic [W-1:0] sum;
      logic         same_in;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      sa      = in_a_ff[W-1];
      sb      = in_b_ff[W-1];
      sum     = (in_op_ff == OP_ADD) ? in_a_ff + in_b_ff : in_a_ff - in_b_ff;
      same_in = (in_op_ff == OP_ADD) ? (sa == sb) : (sa != sb);
      mag_a   = sa ? (~in_a_ff) + 1'b1 : in_a_ff;
      mag_b   = sb ? (~in_b_ff) + 1'b1 : in_b_ff;
      prep_in.op     = in_op_ff;
      prep_in.neg    = sa ^ sb;
      prep_in.dz     = (in_op_ff == OP_DIV) && (in_b_ff == '0);
      prep_in.asr    = (same_in && (sum[W-1] != sa)) ? (sa ? SMIN : SMAX) : sum;
      prep_in.dvs    = mag_b;
      prep_in.rem    = '0;
      prep_in.quo    = mag_a;
      prep_in.mcand  = {{W{1'b0}}, mag_a};
      prep_in.mplier = mag_b;
      prep_in.prod   = '0;
   end

   // Each stage retires one quotient bit and one partial product
   always_comb begin
      logic [W:0] trial;
      logic       ge;
      for (int k = 1; k <= STAGES; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         trial = {pipe_ff[k-1].rem[W-1:0], pipe_ff[k-1].quo[W-1]};
         ge    = trial >= {1'b0, pipe_ff[k-1].dvs};
         pipe_in[k].rem    = ge ? trial - {1'b0, pipe_ff[k-1].dvs} : trial;
         pipe_in[k].quo    = {pipe_ff[k-1].quo[W-2:0], ge};
         pipe_in[k].prod   = pipe_ff[k-1].mplier[0]
                             ? pipe_ff[k-1].prod + pipe_ff[k-1].mcand
                             : pipe_ff[k-1].prod;
         pipe_in[k].mcand  = {pipe_ff[k-1].mcand[2*W-2:0], 1'b0};
         pipe_in[k].mplier = {1'b0, pipe_ff[k-1].mplier[W-1:1]};
      end
   end

   // Advance the stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_vld_ff;
         for (int k = 1; k <= STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      if (adv) begin
         pipe_ff[0] <= prep_in;
         for (int k = 1; k <= STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Select and saturate the final result
   always_comb begin
      logic [W-1:0] hi;
      logic [W-1:0] lo;
      logic [W-1:0] limit;
      logic [W-1:0] q;
      logic         neg;
      neg   = pipe_ff[STAGES].neg;
      hi    = pipe_ff[STAGES].prod[2*W-1:W];
      lo    = pipe_ff[STAGES].prod[W-1:0];
      q     = pipe_ff[STAGES].quo;
      limit = neg ? SMIN : SMAX;
      unique case (pipe_ff[STAGES].op)
         OP_ADD, OP_SUB: begin
            result_in = pipe_ff[STAGES].asr;
         end
         OP_MUL: begin
            if ((hi != '0) || (lo > limit)) begin
               result_in = limit;
            end else begin
               result_in = neg ? (~lo) + 1'b1 : lo;
            end
         end
         OP_DIV: begin
            if (pipe_ff[STAGES].dz) begin
               result_in = '0;
            end else if (!neg && (q > SMAX)) begin
               result_in = SMAX;
            end else begin
               result_in = neg ? (~q) + 1'b1 : q;
            end
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   // Hold the response until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[STAGES];
      end
      if (adv && vld_ff[STAGES]) begin
         result_ff <= result_in;
         dz_ff     <= pipe_ff[STAGES].dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

FILE: src/ssalu_checker.sv
// ----------------------------------------------------------------------------
// Saturating signed ALU checker
// Port-level checks on the ALU, attached to the ALU module by bind.
// ----------------------------------------------------------------------------
`include "saturating_signed_alu_defines.svh"

module ssalu_checker
   import ssalu_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [OP_WIDTH-1:0]          req_operation,
   input logic signed [DATA_WIDTH-1:0] req_operand_a,
   input logic signed [DATA_WIDTH-1:0] req_operand_b,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_result,
   input logic                         rsp_divide_by_zero
);

   logic div_zero_req;

   // Divide with zero divisor seen at the request side
   assign div_zero_req = req_valid && (op_type'(req_operation) == OP_DIV)
                         && (req_operand_b == '0) && (req_operand_a == req_operand_a);

   // Stalled response holds its payload
   `SSALU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result) && $stable(rsp_divide_by_zero),
      "stalled response changed")

   // Zero-divisor flag always comes with a zero result
   `SSALU_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero,
      rsp_result == '0, "divide by zero with nonzero result")

   // Back-pressure only when a held response is stalled
   `SSALU_ASSERT_IMP(a_req_stall, clock, 1'b0, req_stall,
      rsp_valid && rsp_stall, "request stalled without response back-pressure")

   // Reset empties the pipeline
   `SSALU_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset,
      !rsp_valid, "response valid right after reset")

   // A zero-divisor request never stalls with an idle output
   `SSALU_ASSERT_IMP(a_dz_flow, clock, reset, div_zero_req && !rsp_valid,
      !req_stall, "zero-divisor request stalled with idle output")

endmodule

bind saturating_signed_alu ssalu_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_ssalu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_operation      (req_operation),
   .req_operand_a      (req_operand_a),
   .req_operand_b      (req_operand_b),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result         (rsp_result),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
